/* rtl/n2a_pkg.sv */
// shared constants, types and helpers for the number to ascii formatter
package n2a_pkg;

  // bits of the input value taken into the conversion
  localparam int VALUE_BITS = 32;
  localparam int IN_VALUE_W = 32;
  localparam int CONV_BITS  = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

  // decimal digits needed for CONV_BITS bits (1233/4096 ~ log10(2))
  localparam int DEC_DIGITS = ((CONV_BITS * 1233) >> 12) + 1;
  localparam int DIG_W      = DEC_DIGITS * 4;
  localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(CONV_BITS + 1);

  localparam int CODE_W = 7;
  localparam int X_W    = 16;

  localparam logic [X_W-1:0]    CHAR_STEP  = X_W'(8);
  localparam logic [CODE_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CODE_W-1:0] ASCII_A    = 7'h41;
  localparam logic [CODE_W-1:0] ASCII_X    = 7'h78;

  // prefix characters still to send in hex mode
  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_X    = 2'd1;
  localparam logic [1:0] PFX_ZERO = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_DEC,
    OP_LOAD_HEX,
    OP_DABBLE,
    OP_NSHIFT
  } dig_op_e;

  typedef struct packed {
    dig_op_e               op;
    logic [CONV_BITS-1:0]  value;
  } dig_ctrl_t;

  function automatic logic [CODE_W-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CODE_W-1:0] code;
    if (d < 4'd10) begin
      code = ASCII_ZERO + CODE_W'(d);
    end else begin
      code = ASCII_A + CODE_W'(d - 4'd10);
    end
    return code;
  endfunction

endpackage

/* rtl/n2a_digit_sr.sv */
// digit shift register: double dabble conversion and nibble-serial readout
module n2a_digit_sr (
  input  logic               clk_i,
  input  n2a_pkg::dig_ctrl_t ctrl_i,
  output logic [3:0]         top_o
);

  logic [n2a_pkg::CONV_BITS-1:0] val_q, val_d;
  logic [n2a_pkg::DIG_W-1:0]     bcd_q, bcd_d;
  logic [n2a_pkg::DIG_W-1:0]     bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < n2a_pkg::DEC_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    val_d = val_q;
    bcd_d = bcd_q;
    case (ctrl_i.op)
      n2a_pkg::OP_LOAD_DEC: begin
        val_d = ctrl_i.value;
        bcd_d = '0;
      end
      n2a_pkg::OP_LOAD_HEX: begin
        bcd_d = n2a_pkg::DIG_W'(ctrl_i.value);
      end
      n2a_pkg::OP_DABBLE: begin
        bcd_d = {bcd_adj[n2a_pkg::DIG_W-2:0], val_q[n2a_pkg::CONV_BITS-1]};
        val_d = {val_q[n2a_pkg::CONV_BITS-2:0], 1'b0};
      end
      n2a_pkg::OP_NSHIFT: begin
        bcd_d = {bcd_q[n2a_pkg::DIG_W-5:0], 4'h0};
      end
      default: begin
        val_d = val_q;
        bcd_d = bcd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    bcd_q <= bcd_d;
  end

  assign top_o = bcd_q[n2a_pkg::DIG_W-1 -: 4];

endmodule

/* rtl/number_to_ascii_formatter_core.sv */
// number to ascii formatter: decimal or 0x-prefixed hex characters with x positions
//
// channel  | dir | tdata                               | tuser | tlast
// s_axis   | in  | [31:0] value, [47:32] start_x      | mode  | -
// m_axis   | out | [6:0] char_code, [22:7] char_x, 0  | -     | last
//
// one number at a time. decimal: accept, double dabble conversion over every value bit,
// then leading zero digits dropped in skip with at least one digit kept, then the
// characters sent. hex: no conversion, the value is loaded directly, then skip and emit.
// reset clears the state machine and the output valid flag only.
// m_axis stalls during character output hold the sequencer in emit; the next
// number is taken while the final beat of the previous one waits in the output.
module number_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [31:0] value, [47:32] start_x
  input  logic        s_axis_tuser,  // [0] mode: 1 hex, 0 decimal
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [6:0] char_code, [22:7] char_x, [23] zero
  output logic        m_axis_tlast   // final character of the number
);

  n2a_pkg::state_e state_q, state_d;

  logic [n2a_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [n2a_pkg::CNT_W-1:0]     cnt_q, cnt_d;      // digits left in the register
  logic [1:0]                    pfx_q, pfx_d;      // prefix chars left
  logic [n2a_pkg::X_W-1:0]       x_q, x_d;

  // output register
  logic                          ovalid_q, ovalid_d;
  logic [n2a_pkg::CODE_W-1:0]    ocode_q, ocode_d;
  logic [n2a_pkg::X_W-1:0]       ox_q, ox_d;
  logic                          olast_q, olast_d;

  n2a_pkg::dig_ctrl_t dig_ctrl;
  logic [3:0]         top_dig;

  logic in_fire;
  logic slot_free;
  logic emit_fire;
  logic emit_last;

  assign s_axis_tready = (state_q == n2a_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !ovalid_q || m_axis_tready;
  assign emit_fire     = (state_q == n2a_pkg::ST_EMIT) && slot_free;
  assign emit_last     = (pfx_q == n2a_pkg::PFX_NONE) && (cnt_q == n2a_pkg::CNT_W'(1));

  n2a_digit_sr u_digits (
    .clk_i  (clk_i),
    .ctrl_i (dig_ctrl),
    .top_o  (top_dig)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      n2a_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = s_axis_tuser ? n2a_pkg::ST_SKIP : n2a_pkg::ST_CONV;
        end
      end
      n2a_pkg::ST_CONV: begin
        if (bit_cnt_q == n2a_pkg::BIT_CNT_W'(1)) begin
          state_d = n2a_pkg::ST_SKIP;
        end
      end
      n2a_pkg::ST_SKIP: begin
        // leading zeros go one per cycle, keep at least one digit
        if (!(top_dig == 4'h0 && cnt_q > n2a_pkg::CNT_W'(1))) begin
          state_d = n2a_pkg::ST_EMIT;
        end
      end
      n2a_pkg::ST_EMIT: begin
        if (emit_fire && emit_last) begin
          state_d = n2a_pkg::ST_IDLE;
        end
      end
      default: state_d = n2a_pkg::ST_IDLE;
    endcase
  end

  // datapath control and output register loading
  always_comb begin
    dig_ctrl.op    = n2a_pkg::OP_HOLD;
    dig_ctrl.value = s_axis_tdata[n2a_pkg::CONV_BITS-1:0];
    bit_cnt_d      = bit_cnt_q;
    cnt_d          = cnt_q;
    pfx_d          = pfx_q;
    x_d            = x_q;
    ovalid_d       = ovalid_q && !m_axis_tready;
    ocode_d        = ocode_q;
    ox_d           = ox_q;
    olast_d        = olast_q;

    case (state_q)
      n2a_pkg::ST_IDLE: begin
        if (in_fire) begin
          dig_ctrl.op = s_axis_tuser ? n2a_pkg::OP_LOAD_HEX : n2a_pkg::OP_LOAD_DEC;
          bit_cnt_d   = n2a_pkg::BIT_CNT_W'(n2a_pkg::CONV_BITS);
          cnt_d       = n2a_pkg::CNT_W'(n2a_pkg::DEC_DIGITS);
          pfx_d       = s_axis_tuser ? n2a_pkg::PFX_ZERO : n2a_pkg::PFX_NONE;
          x_d         = s_axis_tdata[47:32];
        end
      end
      n2a_pkg::ST_CONV: begin
        dig_ctrl.op = n2a_pkg::OP_DABBLE;
        bit_cnt_d   = bit_cnt_q - n2a_pkg::BIT_CNT_W'(1);
      end
      n2a_pkg::ST_SKIP: begin
        if (top_dig == 4'h0 && cnt_q > n2a_pkg::CNT_W'(1)) begin
          dig_ctrl.op = n2a_pkg::OP_NSHIFT;
          cnt_d       = cnt_q - n2a_pkg::CNT_W'(1);
        end
      end
      n2a_pkg::ST_EMIT: begin
        if (emit_fire) begin
          ovalid_d = 1'b1;
          ox_d     = x_q;
          olast_d  = emit_last;
          x_d      = x_q + n2a_pkg::CHAR_STEP;
          if (pfx_q == n2a_pkg::PFX_ZERO) begin
            ocode_d = n2a_pkg::ASCII_ZERO;
            pfx_d   = n2a_pkg::PFX_X;
          end else if (pfx_q == n2a_pkg::PFX_X) begin
            ocode_d = n2a_pkg::ASCII_X;
            pfx_d   = n2a_pkg::PFX_NONE;
          end else begin
            ocode_d     = n2a_pkg::digit_to_ascii(top_dig);
            dig_ctrl.op = n2a_pkg::OP_NSHIFT;
            cnt_d       = cnt_q - n2a_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        dig_ctrl.op = n2a_pkg::OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= n2a_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_cnt_q <= bit_cnt_d;
    cnt_q     <= cnt_d;
    pfx_q     <= pfx_d;
    x_q       <= x_d;
    ocode_q   <= ocode_d;
    ox_q      <= ox_d;
    olast_q   <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, ox_q, ocode_q};
  assign m_axis_tlast  = olast_q;

`ifndef SYNTH
  // the final character returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && emit_last |=> state_q == n2a_pkg::ST_IDLE)
    else $error("sequencer not idle after final character");

  // conversion never runs with an empty bit counter
  a_conv_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == n2a_pkg::ST_CONV |-> bit_cnt_q != '0)
    else $error("double dabble bit counter underflow");

  // a number always keeps at least one digit to send
  a_digit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == n2a_pkg::ST_SKIP || state_q == n2a_pkg::ST_EMIT) |-> cnt_q != '0)
    else $error("digit count reached zero before the final character");

  // an input beat always starts conversion or, in hex mode, the skip state
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == n2a_pkg::ST_CONV || state_q == n2a_pkg::ST_SKIP)
    else $error("unexpected state after input beat");
`endif

endmodule

/* bench/number_to_ascii_formatter_core_test.sv */
// self-checking bench for the number to ascii formatter core
`timescale 1ns / 1ps

module number_to_ascii_formatter_core_test;

  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  localparam int RANDOM_NUMBERS = 240;
  localparam int HOLD_AFTER     = 200;   // characters seen before the long output stall
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 3000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES  = 80;

  typedef struct {
    logic        mode;
    logic [31:0] value;
    logic [15:0] start_x;
    int          gap;    // idle cycles before this number is offered
    bit          drain;  // hold this number back until every character has come
  } number_req_t;

  typedef struct packed {
    logic [n2a_pkg::CODE_W-1:0] code;
    logic [n2a_pkg::X_W-1:0]    x;
    logic                       last;
  } char_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [31:0] value, [47:32] start_x
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [6:0] char_code, [22:7] char_x, [23] zero
  logic        m_axis_tlast;

  number_req_t pending[$];
  char_beat_t  expected_chars[$];

  number_req_t next_req;
  number_req_t offered;
  bit          have_next = 1'b0;
  int          next_wait = 0;
  int          recv_wait = 0;
  int          chars_predicted = 0;
  int          chars_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;
  int          n_errors = 0;
  int          n_hex = 0;
  int          n_dec = 0;
  int          n_wraps = 0;

  number_to_ascii_formatter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // characters a number turns into, most significant digit first; returns how many
  function automatic int predict_chars(input number_req_t req);
    logic [63:0] n;
    logic [63:0] vmask;
    logic [63:0] base;
    logic [3:0]  digs [0:23];
    int          cnt;
    int          pushed;
    bit          wrapped;
    logic [n2a_pkg::X_W-1:0] x;
    char_beat_t  c;
    vmask = (n2a_pkg::VALUE_BITS >= 64) ? '1 :
            ((64'd1 << n2a_pkg::VALUE_BITS) - 64'd1);
    n = {32'd0, req.value} & vmask;
    base = (req.mode == MODE_HEX) ? 64'd16 : 64'd10;
    cnt = 0;
    pushed = 0;
    wrapped = 1'b0;
    // least significant digit first
    while (n != 0 && cnt < 24) begin
      digs[cnt] = 4'(n % base);
      n = n / base;
      cnt++;
    end
    if (cnt == 0) begin
      digs[0] = 4'd0;
      cnt = 1;
    end
    x = req.start_x;
    if (req.mode == MODE_HEX) begin
      c = '{code: n2a_pkg::ASCII_ZERO, x: x, last: 1'b0};
      expected_chars.push_back(c);
      x = x + n2a_pkg::CHAR_STEP;
      wrapped |= (x < n2a_pkg::CHAR_STEP);
      c = '{code: n2a_pkg::ASCII_X, x: x, last: 1'b0};
      expected_chars.push_back(c);
      x = x + n2a_pkg::CHAR_STEP;
      wrapped |= (x < n2a_pkg::CHAR_STEP);
      pushed = 2;
    end
    for (int i = cnt - 1; i >= 0; i--) begin
      c.code = (digs[i] < 4'd10) ?
               n2a_pkg::ASCII_ZERO + n2a_pkg::CODE_W'(digs[i]) :
               n2a_pkg::ASCII_A + n2a_pkg::CODE_W'(digs[i] - 4'd10);
      c.x    = x;
      c.last = (i == 0);
      expected_chars.push_back(c);
      pushed++;
      if (i != 0) begin
        x = x + n2a_pkg::CHAR_STEP;
        wrapped |= (x < n2a_pkg::CHAR_STEP);
      end
    end
    if (wrapped) n_wraps++;
    return pushed;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at character %0d: got 0x%0h, want 0x%0h",
             what, chars_seen, got, want);
    n_errors++;
  endtask

  task automatic queue_number(input logic mode, input logic [31:0] value,
                              input logic [15:0] start_x, input int gap, input bit drain);
    number_req_t r;
    r.mode    = mode;
    r.value   = value;
    r.start_x = start_x;
    r.gap     = gap;
    r.drain   = drain;
    pending.push_back(r);
  endtask

  // input driver: offers queued numbers after their idle gap, holds while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    int pred_now;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      have_next = 1'b0;
      next_wait = 0;
    end else begin
      pred_now = chars_predicted;
      if (s_axis_tvalid && s_axis_tready) begin
        // number accepted: queue up its characters
        pred_now = pred_now + predict_chars(offered);
        if (offered.mode == MODE_HEX) n_hex++;
        else n_dec++;
      end
      chars_predicted <= pred_now;
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (!have_next && pending.size() != 0 &&
            (!pending[0].drain || pred_now == chars_seen)) begin
          next_req  = pending.pop_front();
          next_wait = next_req.gap;
          have_next = 1'b1;
        end
        if (have_next && next_wait == 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {next_req.start_x, next_req.value};
          s_axis_tuser  <= next_req.mode;
          offered   = next_req;
          have_next = 1'b0;
        end else begin
          if (have_next) next_wait--;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long output stall once the run is under way, so the core backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chars_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor: checks each character beat, then draws its own stall
  always @(posedge clk_i or negedge rst_ni) begin
    char_beat_t want;
    int         stall_max;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("beat with nothing pending", m_axis_tdata, 0);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata[6:0] !== want.code)
            report_mismatch("char_code", m_axis_tdata[6:0], want.code);
          if (m_axis_tdata[22:7] !== want.x)
            report_mismatch("char_x", m_axis_tdata[22:7], want.x);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
          if (m_axis_tdata[23] !== 1'b0)
            report_mismatch("pad bit", m_axis_tdata[23], 0);
        end
        chars_seen <= chars_seen + 1;
        // stall phases rotate: heavy, none, light
        case ((chars_seen / 64) % 3)
          0:       stall_max = 10;
          1:       stall_max = 0;
          default: stall_max = 3;
        endcase
        recv_wait = $urandom_range(0, stall_max);
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: too long with no beat on either side means the core hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] v;
    logic [15:0] sx;
    int          gap;
    bit          burst;

    // directed: zero, field extremes, letters, digit count edges, x wrap
    queue_number(MODE_DEC, 32'd0,          16'd0,     0, 1'b0);
    queue_number(MODE_HEX, 32'd0,          16'hFFFF,  0, 1'b0);
    queue_number(MODE_DEC, 32'hFFFFFFFF,   16'hFFFF,  2, 1'b0);
    queue_number(MODE_HEX, 32'hFFFFFFFF,   16'd0,     0, 1'b0);
    queue_number(MODE_DEC, 32'd1,          16'h1234,  1, 1'b0);
    queue_number(MODE_DEC, 32'd9,          16'd8,     0, 1'b0);
    queue_number(MODE_DEC, 32'd10,         16'hFFF8,  0, 1'b0);
    queue_number(MODE_HEX, 32'hF,          16'hFFF0,  3, 1'b0);
    queue_number(MODE_HEX, 32'h10,         16'hFFFB,  0, 1'b0);
    queue_number(MODE_HEX, 32'hA,          16'h00FF,  0, 1'b0);
    queue_number(MODE_HEX, 32'hDEADBEEF,   16'hAAAA,  5, 1'b0);
    queue_number(MODE_HEX, 32'hABCDEF01,   16'h5555,  0, 1'b0);
    queue_number(MODE_HEX, 32'h80000000,   16'hFFE8,  0, 1'b0);
    queue_number(MODE_DEC, 32'h80000000,   16'h8000,  0, 1'b0);
    queue_number(MODE_DEC, 32'd1000000000, 16'h7FFF,  4, 1'b0);
    queue_number(MODE_DEC, 32'd999999999,  16'hFFD0,  0, 1'b0);
    queue_number(MODE_DEC, 32'h12345678,   16'h0F0F,  0, 1'b0);
    queue_number(MODE_DEC, 32'h55555555,   16'hF0F0,  0, 1'b0);
    queue_number(MODE_HEX, 32'h55555555,   16'h0001,  0, 1'b0);
    queue_number(MODE_DEC, 32'd99999,      16'hFFFE,  0, 1'b0);
    queue_number(MODE_HEX, 32'h00FACE00,   16'hFFF9,  0, 1'b0);

    // random: mix of lengths and modes, bursts without gaps every third block
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      burst = ((i / 30) % 3) == 1;
      case ($urandom_range(0, 3))
        0:       v = $urandom;
        1:       v = $urandom >> $urandom_range(0, 31);
        2:       v = $urandom_range(0, 20);
        default: v = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
      endcase
      if ($urandom_range(0, 7) == 0) sx = 16'hFFFF - 16'($urandom_range(0, 100));
      else sx = 16'($urandom_range(0, 65535));
      gap = burst ? 0 : $urandom_range(0, 10);
      // pause the input until the output has caught up, twice
      queue_number(1'($urandom_range(0, 1)), v, sx, gap, (i == 0) || (i == 130));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || have_next || s_axis_tvalid ||
           chars_seen != chars_predicted)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_chars.size() != 0)
      report_mismatch("characters never seen", 0, expected_chars.size());

    $display("covered %0d numbers (%0d hex, %0d decimal), %0d characters checked",
             n_hex + n_dec, n_hex, n_dec, chars_seen);
    $display("%0d numbers wrapped x, one %0d cycle output stall, input drain pauses",
             n_wraps, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
